### design/dsg_pkg.sv
// ----------------------------------------------------------------------------
// dsg_pkg
// Shared types, widths and codes of the direct-sum gravity query core.
// ----------------------------------------------------------------------------
package dsg_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_PARTICLES_DEF = 1024;
  localparam int FRAC_BITS_DEF     = 16;

  // Fixed field and datapath widths
  localparam int OUT_FRAC   = 24;   // fraction bits of the results
  localparam int IDX_OUT_W  = 10;   // particle_index width
  localparam int VAL_W      = 32;   // mass and coordinates
  localparam int SLEN_W     = 31;   // soft_len
  localparam int OUT_W      = 48;   // result sums
  localparam int SUM_W      = 64;   // running sums
  localparam int SOFT_W     = 64;   // squared softening
  localparam int SQ_W       = 64;   // one squared distance component
  localparam int RAD_W      = 67;   // squared distance incl. softening
  localparam int ROOT_W     = 34;   // floor(sqrt) of RAD_W bits
  localparam int SREM_W     = ROOT_W + 1;
  localparam int LO_W       = 34;   // low slice of the radicand for den product
  localparam int DEN_W      = 101;  // r^2 * r
  localparam int NUM_W      = 112;  // |m| * |d| shifted by up to 48
  localparam int QUOT_W     = 48;   // quotient bits kept
  localparam int DIV_SHIFT  = 48;   // first quotient bit tested (overflow test)
  localparam int STORE_W    = 4 * VAL_W;

  // Operation codes
  typedef enum logic [1:0] {
    FN_LOAD  = 2'd0,
    FN_CLEAR = 2'd1,
    FN_ACC   = 2'd2,
    FN_POT   = 2'd3
  } func_t;

  // Input item
  typedef struct packed {
    func_t                    func;
    logic signed [VAL_W-1:0]  mass;
    logic signed [VAL_W-1:0]  pos_x;
    logic signed [VAL_W-1:0]  pos_y;
    logic signed [VAL_W-1:0]  pos_z;
    logic [SLEN_W-1:0]        soft_len;
    logic                     last_in_batch;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [IDX_OUT_W-1:0]     particle_index;
    logic signed [OUT_W-1:0]  acc_x;
    logic signed [OUT_W-1:0]  acc_y;
    logic signed [OUT_W-1:0]  acc_z;
    logic signed [OUT_W-1:0]  potential;
    logic                     store_overflow;
    logic                     last_out;
  } out_item_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] mag;
  } div_out_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DIFF,
    ST_SQ,
    ST_SUM,
    ST_SQRT,
    ST_MUL0,
    ST_MUL1,
    ST_DIV,
    ST_WAIT,
    ST_DONE
  } state_t;

endpackage

### design/dsg_ram.sv
// ----------------------------------------------------------------------------
// dsg_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module dsg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/dsg_div.sv
// ----------------------------------------------------------------------------
// dsg_div
// Restoring divider, one quotient bit per cycle, with a clamped result.
// ----------------------------------------------------------------------------
module dsg_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dsg_pkg::NUM_W-1:0]  num,
  input  logic [dsg_pkg::DEN_W-1:0]  den,
  output dsg_pkg::div_out_t          res
);

  localparam int DSH_W = dsg_pkg::DEN_W + dsg_pkg::DIV_SHIFT;
  localparam logic [5:0] LAST_STEP = 6'(dsg_pkg::DIV_SHIFT);
  localparam logic [dsg_pkg::QUOT_W-1:0] LIM = {1'b1, {(dsg_pkg::QUOT_W-1){1'b0}}};

  logic [dsg_pkg::NUM_W-1:0]  rem;
  logic [DSH_W-1:0]           dsh;
  logic [DSH_W-1:0]           rem_ext;
  logic [DSH_W-1:0]           diff;
  logic                       ge;
  logic [5:0]                 cnt;
  logic                       busy;
  logic                       done;
  logic                       ovf;
  logic [dsg_pkg::QUOT_W-1:0] quot;

  // Trial subtraction
  always_comb begin
    rem_ext = DSH_W'(rem);
    ge      = (rem_ext >= dsh);
    diff    = rem_ext - dsh;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 6'd1;
      end
    end
  end

  // Datapath: first step only tests for a quotient of 2^48 or more
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= DSH_W'(den) << dsg_pkg::DIV_SHIFT;
      ovf  <= 1'b0;
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= diff[dsg_pkg::NUM_W-1:0];
      end
      dsh <= dsh >> 1;
      if (cnt == 6'd0) begin
        ovf <= ge;
      end else begin
        quot <= {quot[dsg_pkg::QUOT_W-2:0], ge};
      end
    end
  end

  assign res.done = done;
  assign res.mag  = (ovf || (quot > LIM)) ? LIM : quot;

endmodule

### design/direct_sum_gravity_query_core.sv
// A load or clear goes from idle to the done state, which registers its result.
// A query walks all stored particles, each through issue, difference, square and sum,
// the 34-step square root, the multiply steps for acceleration only, and the 49-step
// dividers; a skipped particle ends after the difference. One item is worked on
// at a time; the next can be taken while the last result waits at the output.
// Reset clears the particle count, the overflow flag and soft_sq; store stays undefined.
// ----------------------------------------------------------------------------
// direct_sum_gravity_query_core
// Softened direct-sum gravity over a RAM-held particle store.
// ----------------------------------------------------------------------------
module direct_sum_gravity_query_core #(
  parameter int MAX_PARTICLES = dsg_pkg::MAX_PARTICLES_DEF,
  parameter int FRAC_BITS     = dsg_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  dsg_pkg::in_item_t         item,
  output logic                      result_valid,
  input  logic                      result_stall,
  output dsg_pkg::out_item_t        result,
  input  logic                      cfg_we,
  input  logic [dsg_pkg::VAL_W-1:0] cfg_wdata
);

  localparam int IDX_W = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTICLES);
  localparam int VAL_W = dsg_pkg::VAL_W;
  localparam int SUM_W = dsg_pkg::SUM_W;
  localparam int HI_W  = dsg_pkg::RAD_W - dsg_pkg::LO_W + dsg_pkg::ROOT_W;
  localparam logic signed [SUM_W-1:0] SUM_LIM  = 64'sd1 <<< 62;
  localparam logic signed [SUM_W-1:0] OUT_MAX  = (64'sd1 <<< 47) - 64'sd1;
  localparam logic signed [SUM_W-1:0] OUT_MIN  = -(64'sd1 <<< 47);

  // Saturating add of one term to a running sum
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0] s,
    input logic signed [SUM_W-1:0] t
  );
    logic signed [SUM_W:0] w;
    w = {s[SUM_W-1], s} + {t[SUM_W-1], t};
    if (w > (SUM_W+1)'(SUM_LIM)) begin
      sat_add = SUM_LIM;
    end else if (w < -(SUM_W+1)'(SUM_LIM)) begin
      sat_add = -SUM_LIM;
    end else begin
      sat_add = w[SUM_W-1:0];
    end
  endfunction

  // Saturate a sum to the 48-bit output range
  function automatic logic signed [dsg_pkg::OUT_W-1:0] out48(
    input logic signed [SUM_W-1:0] v
  );
    if (v > OUT_MAX) begin
      out48 = OUT_MAX[dsg_pkg::OUT_W-1:0];
    end else if (v < OUT_MIN) begin
      out48 = OUT_MIN[dsg_pkg::OUT_W-1:0];
    end else begin
      out48 = v[dsg_pkg::OUT_W-1:0];
    end
  endfunction

  dsg_pkg::state_t state, state_next;

  // Control registers
  logic [CNT_W-1:0]        count;
  logic                    ovf_flag;
  logic [VAL_W-1:0]        soft_sq;
  logic [CNT_W-1:0]        idx;

  // Query registers
  dsg_pkg::func_t                  qfunc;
  logic                            qlast;
  logic signed [VAL_W-1:0]         q_x, q_y, q_z;
  logic [dsg_pkg::SOFT_W-1:0]      soft_tot;
  logic                            m_neg;
  logic [VAL_W-1:0]                m_mag;
  logic [VAL_W-1:0]                d_mag [3];
  logic                            d_neg [3];
  logic [dsg_pkg::SQ_W-1:0]        sq    [3];
  logic [2*VAL_W-1:0]              prod  [3];
  logic [dsg_pkg::RAD_W-1:0]       rad;
  logic [dsg_pkg::RAD_W:0]         sh;
  logic [dsg_pkg::SREM_W-1:0]      srem;
  logic [dsg_pkg::ROOT_W-1:0]      root;
  logic [5:0]                      scnt;
  logic [dsg_pkg::LO_W+dsg_pkg::ROOT_W-1:0] p0;
  logic [HI_W-1:0]                 p1;
  logic [dsg_pkg::DEN_W-1:0]       den;
  logic signed [SUM_W-1:0]         acc [3];
  logic signed [SUM_W-1:0]         pot;
  logic [dsg_pkg::IDX_OUT_W-1:0]   res_index;

  // Store
  logic                         st_we;
  logic [dsg_pkg::STORE_W-1:0]  st_rdata;
  logic [CNT_W+dsg_pkg::IDX_OUT_W-1:0] idx_wide;

  // Walk and datapath helpers
  logic                      accept;
  logic                      can_load;
  logic [CNT_W-1:0]          idx_inc;
  logic                      walk_end;
  logic signed [VAL_W:0]     d [3];
  logic signed [VAL_W-1:0]   s_mass;
  logic                      skip;
  logic                      div_start;
  logic                      out_free;
  logic [dsg_pkg::SREM_W+1:0] rt, trial;
  logic [dsg_pkg::DEN_W-1:0] den_in;
  logic [dsg_pkg::NUM_W-1:0] num_in [3];
  dsg_pkg::div_out_t         div_res [3];

  assign accept   = item_valid && (state == dsg_pkg::ST_IDLE);
  assign can_load = (count < CNT_MAX);
  assign idx_inc  = idx + CNT_W'(1);
  assign walk_end = (idx_inc >= count);
  assign out_free = !result_valid || !result_stall;
  assign item_stall = (state != dsg_pkg::ST_IDLE);
  assign st_we    = accept && (item.func == dsg_pkg::FN_LOAD) && can_load;
  assign idx_wide = {{dsg_pkg::IDX_OUT_W{1'b0}}, count};

  dsg_ram #(
    .WIDTH (dsg_pkg::STORE_W),
    .DEPTH (MAX_PARTICLES)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (count[IDX_W-1:0]),
    .wdata ({item.mass, item.pos_x, item.pos_y, item.pos_z}),
    .raddr (idx[IDX_W-1:0]),
    .rdata (st_rdata)
  );

  // Distance from the query point to the stored particle
  always_comb begin
    s_mass = st_rdata[4*VAL_W-1:3*VAL_W];
    d[0] = {st_rdata[3*VAL_W-1], st_rdata[3*VAL_W-1:2*VAL_W]} - {q_x[VAL_W-1], q_x};
    d[1] = {st_rdata[2*VAL_W-1], st_rdata[2*VAL_W-1:VAL_W]} - {q_y[VAL_W-1], q_y};
    d[2] = {st_rdata[VAL_W-1], st_rdata[VAL_W-1:0]} - {q_z[VAL_W-1], q_z};
    skip = ((d[0] == '0) && (d[1] == '0) && (d[2] == '0)) ||
           ((qfunc == dsg_pkg::FN_POT) && (s_mass <= 0));
  end

  // Square root step
  always_comb begin
    rt    = {srem, sh[dsg_pkg::RAD_W:dsg_pkg::RAD_W-1]};
    trial = (dsg_pkg::SREM_W+2)'({root, 2'b01});
  end

  // Divider operands
  always_comb begin
    den_in = (qfunc == dsg_pkg::FN_ACC) ? den : dsg_pkg::DEN_W'(root);
    for (int k = 0; k < 3; k++) begin
      num_in[k] = dsg_pkg::NUM_W'(prod[k]) << (FRAC_BITS + dsg_pkg::OUT_FRAC);
    end
    if (qfunc == dsg_pkg::FN_POT) begin
      num_in[0] = dsg_pkg::NUM_W'(m_mag) << dsg_pkg::OUT_FRAC;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    dsg_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (num_in[k]),
      .den   (den_in),
      .res   (div_res[k])
    );
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      dsg_pkg::ST_IDLE: begin
        if (item_valid) begin
          unique case (item.func)
            dsg_pkg::FN_LOAD, dsg_pkg::FN_CLEAR: state_next = dsg_pkg::ST_DONE;
            default: state_next = (count == '0) ? dsg_pkg::ST_DONE : dsg_pkg::ST_ISSUE;
          endcase
        end
      end
      dsg_pkg::ST_ISSUE: state_next = dsg_pkg::ST_DIFF;
      dsg_pkg::ST_DIFF: begin
        if (skip) begin
          state_next = walk_end ? dsg_pkg::ST_DONE : dsg_pkg::ST_ISSUE;
        end else begin
          state_next = dsg_pkg::ST_SQ;
        end
      end
      dsg_pkg::ST_SQ:  state_next = dsg_pkg::ST_SUM;
      dsg_pkg::ST_SUM: state_next = dsg_pkg::ST_SQRT;
      dsg_pkg::ST_SQRT: begin
        if (scnt == 6'(dsg_pkg::ROOT_W - 1)) begin
          state_next = (qfunc == dsg_pkg::FN_ACC) ? dsg_pkg::ST_MUL0 : dsg_pkg::ST_DIV;
        end
      end
      dsg_pkg::ST_MUL0: state_next = dsg_pkg::ST_MUL1;
      dsg_pkg::ST_MUL1: state_next = dsg_pkg::ST_DIV;
      dsg_pkg::ST_DIV: begin
        div_start  = 1'b1;
        state_next = dsg_pkg::ST_WAIT;
      end
      dsg_pkg::ST_WAIT: begin
        if (div_res[0].done) begin
          state_next = walk_end ? dsg_pkg::ST_DONE : dsg_pkg::ST_ISSUE;
        end
      end
      dsg_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = dsg_pkg::ST_IDLE;
        end
      end
      default: state_next = dsg_pkg::ST_IDLE;
    endcase
  end

  // Control state: count, flag, register, walk index, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      ovf_flag     <= 1'b0;
      soft_sq      <= '0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        soft_sq <= cfg_wdata;
      end
      if (accept) begin
        idx <= '0;
        case (item.func)
          dsg_pkg::FN_LOAD: begin
            if (can_load) begin
              count <= count + CNT_W'(1);
            end else begin
              ovf_flag <= 1'b1;
            end
          end
          dsg_pkg::FN_CLEAR: count <= '0;
          default: ;
        endcase
      end
      if (((state == dsg_pkg::ST_DIFF) && skip) ||
          ((state == dsg_pkg::ST_WAIT) && div_res[0].done)) begin
        idx <= idx_inc;
      end
      if ((state == dsg_pkg::ST_DONE) && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      qfunc     <= item.func;
      qlast     <= item.last_in_batch;
      q_x       <= item.pos_x;
      q_y       <= item.pos_y;
      q_z       <= item.pos_z;
      soft_tot  <= (dsg_pkg::SOFT_W'(soft_sq) << FRAC_BITS) +
                   dsg_pkg::SOFT_W'(item.soft_len) * dsg_pkg::SOFT_W'(item.soft_len);
      res_index <= st_we ? idx_wide[dsg_pkg::IDX_OUT_W-1:0] : '0;
      pot       <= '0;
      for (int k = 0; k < 3; k++) begin
        acc[k] <= '0;
      end
    end

    case (state)
      dsg_pkg::ST_DIFF: begin
        m_neg <= s_mass[VAL_W-1];
        m_mag <= s_mass[VAL_W-1] ? VAL_W'(-s_mass) : VAL_W'(s_mass);
        for (int k = 0; k < 3; k++) begin
          d_neg[k] <= d[k][VAL_W];
          d_mag[k] <= d[k][VAL_W] ? VAL_W'(-d[k]) : VAL_W'(d[k]);
        end
      end
      dsg_pkg::ST_SQ: begin
        for (int k = 0; k < 3; k++) begin
          sq[k]   <= d_mag[k] * d_mag[k];
          prod[k] <= m_mag * d_mag[k];
        end
      end
      dsg_pkg::ST_SUM: begin
        rad  <= dsg_pkg::RAD_W'(soft_tot) + dsg_pkg::RAD_W'(sq[0]) +
                dsg_pkg::RAD_W'(sq[1]) + dsg_pkg::RAD_W'(sq[2]);
        sh   <= {1'b0, dsg_pkg::RAD_W'(soft_tot) + dsg_pkg::RAD_W'(sq[0]) +
                dsg_pkg::RAD_W'(sq[1]) + dsg_pkg::RAD_W'(sq[2])};
        srem <= '0;
        root <= '0;
        scnt <= '0;
      end
      dsg_pkg::ST_SQRT: begin
        // one result bit per cycle, two radicand bits consumed
        if (rt >= trial) begin
          srem <= dsg_pkg::SREM_W'(rt - trial);
          root <= {root[dsg_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          srem <= dsg_pkg::SREM_W'(rt);
          root <= {root[dsg_pkg::ROOT_W-2:0], 1'b0};
        end
        sh   <= sh << 2;
        scnt <= scnt + 6'd1;
      end
      dsg_pkg::ST_MUL0: begin
        p0 <= rad[dsg_pkg::LO_W-1:0] * root;
        p1 <= rad[dsg_pkg::RAD_W-1:dsg_pkg::LO_W] * root;
      end
      dsg_pkg::ST_MUL1: begin
        den <= dsg_pkg::DEN_W'(p0) + (dsg_pkg::DEN_W'(p1) << dsg_pkg::LO_W);
      end
      dsg_pkg::ST_WAIT: begin
        if (div_res[0].done) begin
          if (qfunc == dsg_pkg::FN_ACC) begin
            for (int k = 0; k < 3; k++) begin
              acc[k] <= sat_add(acc[k], (m_neg != d_neg[k]) ?
                                -SUM_W'(div_res[k].mag) : SUM_W'(div_res[k].mag));
            end
          end else begin
            pot <= sat_add(pot, -SUM_W'(div_res[0].mag));
          end
        end
      end
      dsg_pkg::ST_DONE: begin
        if (out_free) begin
          result.particle_index <= res_index;
          result.acc_x          <= out48(acc[0]);
          result.acc_y          <= out48(acc[1]);
          result.acc_z          <= out48(acc[2]);
          result.potential      <= out48(pot);
          result.store_overflow <= ovf_flag;
          result.last_out       <= qlast;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // The store never holds more than its depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_MAX)
    else $error("particle count beyond store depth");

  // An accepted load into a non-full store advances the count by one
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    accept && (item.func == dsg_pkg::FN_LOAD) && can_load |=>
      count == $past(count) + CNT_W'(1))
    else $error("load did not advance particle count");

  // The walk only reads stored particles
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == dsg_pkg::ST_DIFF) |-> (idx < count))
    else $error("query read past particle count");

  // Divider results only arrive while the sequencer waits for them
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_res[0].done |-> (state == dsg_pkg::ST_WAIT))
    else $error("divider finished outside wait state");
`endif

endmodule
